FILE: sv/pmaqi_pkg.sv
// Shared types, constants and AQI segment tables for the particulate frame parser.
package pmaqi_pkg;

   localparam logic [7:0]  START_A    = 8'h42;
   localparam logic [7:0]  START_B    = 8'h4D;
   localparam logic [15:0] LEN_WORD   = 16'd28;
   localparam logic [8:0]  AQI_CAP    = 9'd500;
   localparam logic [19:0] CONC_MAX   = 20'd5004;

   localparam logic [4:0]  POS_LEN_HI = 5'd2;
   localparam logic [4:0]  POS_LEN_LO = 5'd3;
   localparam logic [4:0]  POS_PM1_HI = 5'd4;
   localparam logic [4:0]  POS_PM1_LO = 5'd5;
   localparam logic [4:0]  POS_PM25_HI = 5'd6;
   localparam logic [4:0]  POS_PM25_LO = 5'd7;
   localparam logic [4:0]  POS_PM10_HI = 5'd8;
   localparam logic [4:0]  POS_PM10_LO = 5'd9;
   localparam logic [4:0]  POS_SUM_HI = 5'd30;
   localparam logic [4:0]  POS_SUM_LO = 5'd31;

   localparam int          SEG_COUNT  = 7;
   localparam int          NUM_W      = 18;
   localparam int          DEN_W      = 11;
   localparam int          DIV_STEPS  = NUM_W;
   localparam int          CNT_W      = $clog2(DIV_STEPS);

   localparam logic [12:0] SEG_C_LO [SEG_COUNT] =
      '{13'd0, 13'd121, 13'd355, 13'd555, 13'd1505, 13'd2505, 13'd3505};
   localparam logic [12:0] SEG_C_HI [SEG_COUNT] =
      '{13'd120, 13'd354, 13'd554, 13'd1504, 13'd2504, 13'd3504, 13'd5004};
   localparam logic [8:0]  SEG_I_LO [SEG_COUNT] =
      '{9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301, 9'd401};
   localparam logic [6:0]  SEG_SPAN [SEG_COUNT] =
      '{7'd50, 7'd49, 7'd49, 7'd49, 7'd99, 7'd99, 7'd99};
   localparam logic [10:0] SEG_DEN  [SEG_COUNT] =
      '{11'd120, 11'd233, 11'd199, 11'd949, 11'd999, 11'd999, 11'd1499};

   localparam logic [2:0]  CAT_GOOD        = 3'd0;
   localparam logic [2:0]  CAT_MODERATE    = 3'd1;
   localparam logic [2:0]  CAT_SENSITIVE   = 3'd2;
   localparam logic [2:0]  CAT_UNHEALTHY   = 3'd3;
   localparam logic [2:0]  CAT_VERY_UNHLTH = 3'd4;
   localparam logic [2:0]  CAT_HAZARDOUS   = 3'd5;

   localparam logic        STATUS_OK  = 1'b0;
   localparam logic        STATUS_BAD = 1'b1;

   typedef struct packed {
      logic       accept;
      logic       in_frame;
      logic [4:0] pos;
      logic       sum_init;
      logic       aq_seg;
      logic       aq_mul;
      logic       aq_div;
      logic       aq_fin;
      logic       rsp_load;
   } pmaqi_cmd_type;

   typedef struct packed {
      logic is_start_a;
      logic is_start_b;
      logic len_ok;
   } pmaqi_sts_type;

   function automatic logic [2:0] aqi_category(input logic [8:0] aqi);
      logic [2:0] cat;
      if (aqi <= 9'd50) cat = CAT_GOOD;
      else if (aqi <= 9'd100) cat = CAT_MODERATE;
      else if (aqi <= 9'd150) cat = CAT_SENSITIVE;
      else if (aqi <= 9'd200) cat = CAT_UNHEALTHY;
      else if (aqi <= 9'd300) cat = CAT_VERY_UNHLTH;
      else cat = CAT_HAZARDOUS;
      return cat;
   endfunction

endpackage

FILE: sv/pmaqi_datapath.sv
// Datapath: checksum, PM word capture, AQI interpolation unit and result registers.
module pmaqi_datapath (
   input  logic                    clock,
   input  logic [7:0]              rx_byte,
   input  pmaqi_pkg::pmaqi_cmd_type cmd,
   output pmaqi_pkg::pmaqi_sts_type sts,
   output logic                    frame_status,
   output logic [15:0]             pm1_value,
   output logic [15:0]             pm25_value,
   output logic [15:0]             pm10_value,
   output logic [8:0]              aqi_index,
   output logic [2:0]              aqi_category
);
   import pmaqi_pkg::*;

   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       len_hi_ff, len_hi_in;
   logic [7:0]       chk_hi_ff, chk_hi_in;
   logic [15:0]      pm1_ff, pm1_in;
   logic [15:0]      pm25_ff, pm25_in;
   logic [15:0]      pm10_ff, pm10_in;

   logic [DEN_W-1:0] diff_ff, diff_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [6:0]       span_ff, span_in;
   logic [8:0]       ilo_ff, ilo_in;
   logic             sat_ff, sat_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [8:0]       aqi_ff, aqi_in;
   logic [2:0]       cat_ff, cat_in;

   logic             status_ff, status_in;
   logic [15:0]      out_pm1_ff, out_pm1_in;
   logic [15:0]      out_pm25_ff, out_pm25_in;
   logic [15:0]      out_pm10_ff, out_pm10_in;
   logic [8:0]       out_aqi_ff, out_aqi_in;
   logic [2:0]       out_cat_ff, out_cat_in;

   logic [19:0]      conc;
   logic [2:0]       sel;
   logic [19:0]      conc_off;
   logic [DEN_W:0]   trial;
   logic             qbit;
   logic             chk_ok;
   logic             frame_acc;

   assign frame_acc = cmd.accept && cmd.in_frame;
   assign chk_ok    = ({chk_hi_ff, rx_byte} == sum_ff);

   assign sts.is_start_a = (rx_byte == START_A);
   assign sts.is_start_b = (rx_byte == START_B);
   assign sts.len_ok     = ({len_hi_ff, rx_byte} == LEN_WORD);

   // byte capture and running checksum
   always_comb begin
      sum_in    = sum_ff;
      len_hi_in = len_hi_ff;
      chk_hi_in = chk_hi_ff;
      pm1_in    = pm1_ff;
      pm25_in   = pm25_ff;
      pm10_in   = pm10_ff;
      if (cmd.sum_init) begin
         sum_in = 16'(START_A) + 16'(START_B);
      end
      if (frame_acc) begin
         if (cmd.pos < POS_SUM_HI) begin
            sum_in = sum_ff + 16'(rx_byte);
         end
         case (cmd.pos)
            POS_LEN_HI:  len_hi_in = rx_byte;
            POS_PM1_HI:  pm1_in    = {rx_byte, 8'h00};
            POS_PM1_LO:  pm1_in    = {pm1_ff[15:8], rx_byte};
            POS_PM25_HI: pm25_in   = {rx_byte, 8'h00};
            POS_PM25_LO: pm25_in   = {pm25_ff[15:8], rx_byte};
            POS_PM10_HI: pm10_in   = {rx_byte, 8'h00};
            POS_PM10_LO: pm10_in   = {pm10_ff[15:8], rx_byte};
            POS_SUM_HI:  chk_hi_in = rx_byte;
            default: ;
         endcase
      end
   end

   // segment lookup on PM2.5 in tenths
   always_comb begin
      conc = {1'b0, pm25_ff, 3'b000} + {3'b000, pm25_ff, 1'b0};
      sel  = 3'd0;
      for (int k = SEG_COUNT - 1; k >= 0; k--) begin
         if (conc <= {7'd0, SEG_C_HI[k]}) sel = 3'(k);
      end
      conc_off = conc - {7'd0, SEG_C_LO[sel]};
   end

   // AQI unit: segment, multiply, restoring divide, offset
   always_comb begin
      diff_in = diff_ff;
      den_in  = den_ff;
      span_in = span_ff;
      ilo_in  = ilo_ff;
      sat_in  = sat_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      aqi_in  = aqi_ff;
      cat_in  = cat_ff;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      qbit    = (trial >= {1'b0, den_ff});
      if (cmd.aq_seg) begin
         diff_in = conc_off[DEN_W-1:0];
         den_in  = SEG_DEN[sel];
         span_in = SEG_SPAN[sel];
         ilo_in  = SEG_I_LO[sel];
         sat_in  = (conc > CONC_MAX);
      end
      if (cmd.aq_mul) begin
         num_in = NUM_W'(span_ff * diff_ff);
         rem_in = '0;
      end
      if (cmd.aq_div) begin
         rem_in = qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], qbit};
      end
      if (cmd.aq_fin) begin
         aqi_in = sat_ff ? AQI_CAP : (num_ff[8:0] + ilo_ff);
         cat_in = pmaqi_pkg::aqi_category(aqi_in);
      end
   end

   // result registers
   always_comb begin
      status_in   = status_ff;
      out_pm1_in  = out_pm1_ff;
      out_pm25_in = out_pm25_ff;
      out_pm10_in = out_pm10_ff;
      out_aqi_in  = out_aqi_ff;
      out_cat_in  = out_cat_ff;
      if (cmd.rsp_load) begin
         if (chk_ok) begin
            status_in   = STATUS_OK;
            out_pm1_in  = pm1_ff;
            out_pm25_in = pm25_ff;
            out_pm10_in = pm10_ff;
            out_aqi_in  = aqi_ff;
            out_cat_in  = cat_ff;
         end else begin
            status_in   = STATUS_BAD;
            out_pm1_in  = '0;
            out_pm25_in = '0;
            out_pm10_in = '0;
            out_aqi_in  = '0;
            out_cat_in  = CAT_GOOD;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      len_hi_ff   <= len_hi_in;
      chk_hi_ff   <= chk_hi_in;
      pm1_ff      <= pm1_in;
      pm25_ff     <= pm25_in;
      pm10_ff     <= pm10_in;
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      span_ff     <= span_in;
      ilo_ff      <= ilo_in;
      sat_ff      <= sat_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      aqi_ff      <= aqi_in;
      cat_ff      <= cat_in;
      status_ff   <= status_in;
      out_pm1_ff  <= out_pm1_in;
      out_pm25_ff <= out_pm25_in;
      out_pm10_ff <= out_pm10_in;
      out_aqi_ff  <= out_aqi_in;
      out_cat_ff  <= out_cat_in;
   end

   assign frame_status = status_ff;
   assign pm1_value    = out_pm1_ff;
   assign pm25_value   = out_pm25_ff;
   assign pm10_value   = out_pm10_ff;
   assign aqi_index    = out_aqi_ff;
   assign aqi_category = out_cat_ff;

endmodule

FILE: sv/pmaqi_ctrl.sv
// Controller: frame hunt/position tracking, AQI sequencer and handshake control.
module pmaqi_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  pmaqi_pkg::pmaqi_sts_type sts,
   output pmaqi_pkg::pmaqi_cmd_type cmd
);
   import pmaqi_pkg::*;

   localparam logic       FRM_HUNT = 1'b0;
   localparam logic       FRM_DATA = 1'b1;

   localparam logic [2:0] AQ_IDLE = 3'd0;
   localparam logic [2:0] AQ_SEG  = 3'd1;
   localparam logic [2:0] AQ_MUL  = 3'd2;
   localparam logic [2:0] AQ_DIV  = 3'd3;
   localparam logic [2:0] AQ_FIN  = 3'd4;

   logic             frm_ff, frm_in;
   logic [4:0]       pos_ff, pos_in;
   logic [2:0]       aq_ff, aq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             aq_busy;
   logic             slot_busy;
   logic             eop_acc;
   logic             aq_start;
   logic             in_frame;

   assign in_frame  = (frm_ff == FRM_DATA);
   assign aq_busy   = (aq_ff != AQ_IDLE);
   assign slot_busy = rsp_valid_ff && rsp_stall;
   assign req_stall = in_frame && (((pos_ff == POS_SUM_LO) && (aq_busy || slot_busy)) ||
                                   ((pos_ff == POS_PM25_LO) && aq_busy));
   assign accept    = req_valid && !req_stall;
   assign eop_acc   = accept && in_frame && (pos_ff == POS_SUM_LO);
   assign aq_start  = accept && in_frame && (pos_ff == POS_PM25_LO);

   always_comb begin
      frm_in = frm_ff;
      pos_in = pos_ff;
      if (accept) begin
         case (frm_ff)
            FRM_HUNT: begin
               if ((pos_ff == 5'd1) && sts.is_start_b) begin
                  frm_in = FRM_DATA;
                  pos_in = POS_LEN_HI;
               end else begin
                  pos_in = sts.is_start_a ? 5'd1 : 5'd0;
               end
            end
            FRM_DATA: begin
               if ((pos_ff == POS_LEN_LO) && !sts.len_ok) begin
                  frm_in = FRM_HUNT;
                  pos_in = sts.is_start_a ? 5'd1 : 5'd0;
               end else if (pos_ff == POS_SUM_LO) begin
                  frm_in = FRM_HUNT;
                  pos_in = 5'd0;
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            default: begin
               frm_in = FRM_HUNT;
               pos_in = 5'd0;
            end
         endcase
      end
   end

   always_comb begin
      aq_in  = aq_ff;
      cnt_in = cnt_ff;
      case (aq_ff)
         AQ_IDLE: if (aq_start) aq_in = AQ_SEG;
         AQ_SEG:  aq_in = AQ_MUL;
         AQ_MUL: begin
            aq_in  = AQ_DIV;
            cnt_in = CNT_W'(DIV_STEPS - 1);
         end
         AQ_DIV: begin
            if (cnt_ff == '0) aq_in = AQ_FIN;
            else cnt_in = cnt_ff - CNT_W'(1);
         end
         AQ_FIN:  aq_in = AQ_IDLE;
         default: aq_in = AQ_IDLE;
      endcase
   end

   assign rsp_valid_in = eop_acc || slot_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         frm_ff       <= FRM_HUNT;
         pos_ff       <= 5'd0;
         aq_ff        <= AQ_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frm_ff       <= frm_in;
         pos_ff       <= pos_in;
         aq_ff        <= aq_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign cmd.accept    = accept;
   assign cmd.in_frame  = in_frame;
   assign cmd.pos       = pos_ff;
   assign cmd.sum_init  = accept && !in_frame && (pos_ff == 5'd1) && sts.is_start_b;
   assign cmd.aq_seg    = (aq_ff == AQ_SEG);
   assign cmd.aq_mul    = (aq_ff == AQ_MUL);
   assign cmd.aq_div    = (aq_ff == AQ_DIV);
   assign cmd.aq_fin    = (aq_ff == AQ_FIN);
   assign cmd.rsp_load  = eop_acc;

   a_eop_aqi_ready: assert property (@(posedge clock) disable iff (reset)
      eop_acc |-> (aq_ff == AQ_IDLE))
      else $error("frame end taken while AQI unit busy");

   a_hunt_pos: assert property (@(posedge clock) disable iff (reset)
      (frm_ff == FRM_HUNT) |-> (pos_ff <= 5'd1))
      else $error("hunt position out of range");

   a_seg_to_mul: assert property (@(posedge clock) disable iff (reset)
      (aq_ff == AQ_SEG) |=> (aq_ff == AQ_MUL))
      else $error("AQI sequencer skipped multiply");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(eop_acc))
      else $error("result raised without frame end");

endmodule

FILE: sv/pm_sensor_frame_parser_aqi_core.sv
// Top level of the particulate sensor frame parser with EPA AQI.
// Takes one serial byte per transaction, one per cycle while not stalled. Frames start with 0x42 0x4D,
// carry a length word of 28 and end at byte 31 with a checksum; each completed frame gives
// one result transaction (status ok with PM1.0/PM2.5/PM10, AQI and category, or status bad).
// A bad length word drops back to hunting with no result. The AQI unit starts when the
// PM2.5 low byte (byte 7) is taken and runs segment lookup, multiply, restoring divide and
// offset in that order; the last frame byte is held off until it is finished and until the
// result register is free.
module pm_sensor_frame_parser_aqi_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_status,
   output logic [15:0] rsp_pm1_value,
   output logic [15:0] rsp_pm25_value,
   output logic [15:0] rsp_pm10_value,
   output logic [8:0]  rsp_aqi_index,
   output logic [2:0]  rsp_aqi_category
);
   import pmaqi_pkg::*;

   pmaqi_cmd_type cmd;
   pmaqi_sts_type sts;

   pmaqi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pmaqi_datapath u_datapath (
      .clock        (clock),
      .rx_byte      (req_rx_byte),
      .cmd          (cmd),
      .sts          (sts),
      .frame_status (rsp_frame_status),
      .pm1_value    (rsp_pm1_value),
      .pm25_value   (rsp_pm25_value),
      .pm10_value   (rsp_pm10_value),
      .aqi_index    (rsp_aqi_index),
      .aqi_category (rsp_aqi_category)
   );

endmodule

FILE: verif/pm_sensor_frame_parser_aqi_core_tb.sv
// Testbench for the particulate frame parser: random byte streams checked against a frame predictor.
module pm_sensor_frame_parser_aqi_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pmaqi_pkg::*;

   localparam int unsigned IDLE_LIMIT = 4000;
   localparam int unsigned RANDOM_BYTES = 1800;
   localparam int unsigned PAUSE_EVERY = 600;

   typedef struct packed {
      logic        status;
      logic [15:0] pm1;
      logic [15:0] pm25;
      logic [15:0] pm10;
      logic [8:0]  aqi;
      logic [2:0]  category;
   } frame_report_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_frame_status;
   logic [15:0] rsp_pm1_value;
   logic [15:0] rsp_pm25_value;
   logic [15:0] rsp_pm10_value;
   logic [8:0]  rsp_aqi_index;
   logic [2:0]  rsp_aqi_category;

   logic [7:0]       rx_bytes_q [$];
   frame_report_type frame_reports_q [$];
   int unsigned      stim_count = 0;
   int unsigned      mismatches = 0;
   int unsigned      idle_cycles = 0;

   // parser image
   logic [4:0]  hunt_pos = '0;
   logic        framing = 1'b0;
   logic [15:0] byte_sum = '0;
   logic [7:0]  len_hi_b = '0;
   logic [7:0]  chk_hi_b = '0;
   logic [15:0] pm1_w = '0;
   logic [15:0] pm25_w = '0;
   logic [15:0] pm10_w = '0;

   pm_sensor_frame_parser_aqi_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_status (rsp_frame_status),
      .rsp_pm1_value    (rsp_pm1_value),
      .rsp_pm25_value   (rsp_pm25_value),
      .rsp_pm10_value   (rsp_pm10_value),
      .rsp_aqi_index    (rsp_aqi_index),
      .rsp_aqi_category (rsp_aqi_category)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // EPA breakpoints, concentration in 0.1 ug/m3
   function automatic logic [8:0] aqi_from_pm25(input logic [15:0] pm25);
      int unsigned conc;
      int unsigned c_lo;
      int unsigned c_hi;
      int unsigned i_lo;
      int unsigned i_hi;
      conc = pm25;
      conc = conc * 10;
      if (conc <= 120) begin
         c_lo = 0;    c_hi = 120;  i_lo = 0;   i_hi = 50;
      end else if (conc <= 354) begin
         c_lo = 121;  c_hi = 354;  i_lo = 51;  i_hi = 100;
      end else if (conc <= 554) begin
         c_lo = 355;  c_hi = 554;  i_lo = 101; i_hi = 150;
      end else if (conc <= 1504) begin
         c_lo = 555;  c_hi = 1504; i_lo = 151; i_hi = 200;
      end else if (conc <= 2504) begin
         c_lo = 1505; c_hi = 2504; i_lo = 201; i_hi = 300;
      end else if (conc <= 3504) begin
         c_lo = 2505; c_hi = 3504; i_lo = 301; i_hi = 400;
      end else if (conc <= 5004) begin
         c_lo = 3505; c_hi = 5004; i_lo = 401; i_hi = 500;
      end else begin
         return AQI_CAP;
      end
      return 9'((i_hi - i_lo) * (conc - c_lo) / (c_hi - c_lo) + i_lo);
   endfunction

   function automatic logic [2:0] band_of(input logic [8:0] aqi);
      if (aqi <= 50) return CAT_GOOD;
      if (aqi <= 100) return CAT_MODERATE;
      if (aqi <= 150) return CAT_SENSITIVE;
      if (aqi <= 200) return CAT_UNHEALTHY;
      if (aqi <= 300) return CAT_VERY_UNHLTH;
      return CAT_HAZARDOUS;
   endfunction

   task automatic track_byte(input logic [7:0] b);
      frame_report_type rep;
      logic [15:0]      chk;
      if (!framing) begin
         if (hunt_pos == 5'd1 && b == START_B) begin
            framing = 1'b1;
            hunt_pos = 5'd2;
            byte_sum = 16'(START_A) + 16'(START_B);
         end else begin
            hunt_pos = (b == START_A) ? 5'd1 : 5'd0;
         end
         return;
      end
      if (hunt_pos < 5'd30) byte_sum = byte_sum + 16'(b);
      case (hunt_pos)
         5'd2: len_hi_b = b;
         5'd3: begin
            if ({len_hi_b, b} != LEN_WORD) begin
               framing = 1'b0;
               hunt_pos = (b == START_A) ? 5'd1 : 5'd0;
               return;
            end
         end
         5'd4: pm1_w = {b, 8'h00};
         5'd5: pm1_w = pm1_w | 16'(b);
         5'd6: pm25_w = {b, 8'h00};
         5'd7: pm25_w = pm25_w | 16'(b);
         5'd8: pm10_w = {b, 8'h00};
         5'd9: pm10_w = pm10_w | 16'(b);
         5'd30: chk_hi_b = b;
         default: ;
      endcase
      if (hunt_pos == 5'd31) begin
         chk = {chk_hi_b, b};
         framing = 1'b0;
         hunt_pos = 5'd0;
         rep = '0;
         if (chk != byte_sum) begin
            rep.status = STATUS_BAD;
         end else begin
            rep.status = STATUS_OK;
            rep.pm1 = pm1_w;
            rep.pm25 = pm25_w;
            rep.pm10 = pm10_w;
            rep.aqi = aqi_from_pm25(pm25_w);
            rep.category = band_of(rep.aqi);
         end
         frame_reports_q.push_back(rep);
         return;
      end
      hunt_pos = hunt_pos + 5'd1;
   endtask

   task automatic push_byte(input logic [7:0] b);
      rx_bytes_q.push_back(b);
      stim_count++;
   endtask

   // bytes first..last of a frame; a wrong length word or a corrupted checksum on request
   task automatic push_frame(input logic [15:0] pm1, input logic [15:0] pm25,
                             input logic [15:0] pm10, input logic [15:0] len_word,
                             input bit bad_sum, input int first, input int last);
      logic [7:0]  fb [32];
      logic [15:0] sum;
      int          i;
      fb[0] = START_A;
      fb[1] = START_B;
      fb[2] = len_word[15:8];
      fb[3] = len_word[7:0];
      fb[4] = pm1[15:8];
      fb[5] = pm1[7:0];
      fb[6] = pm25[15:8];
      fb[7] = pm25[7:0];
      fb[8] = pm10[15:8];
      fb[9] = pm10[7:0];
      for (i = 10; i < 30; i++) fb[i] = 8'($urandom_range(0, 255));
      sum = '0;
      for (i = 0; i < 30; i++) sum = sum + 16'(fb[i]);
      if (bad_sum) sum = sum ^ 16'($urandom_range(1, 65535));
      fb[30] = sum[15:8];
      fb[31] = sum[7:0];
      for (i = first; i <= last; i++) push_byte(fb[i]);
   endtask

   function automatic logic [15:0] pick_pm25();
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            case ($urandom_range(0, 13))
               0: v = 16'd12;
               1: v = 16'd13;
               2: v = 16'd35;
               3: v = 16'd36;
               4: v = 16'd55;
               5: v = 16'd56;
               6: v = 16'd150;
               7: v = 16'd151;
               8: v = 16'd250;
               9: v = 16'd251;
               10: v = 16'd350;
               11: v = 16'd351;
               12: v = 16'd500;
               default: v = 16'd501;
            endcase
         end
         8: v = 16'($urandom_range(0, 65535));
         9: v = 16'($urandom_range(501, 2000));
         default: v = 16'($urandom_range(0, 510));
      endcase
      return v;
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (rx_bytes_q.size() != 0 || req_valid || frame_reports_q.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   initial begin : stimulus
      int unsigned pick;
      int unsigned next_pause;
      int          n;
      logic [15:0] len_word;

      // noise, lone second start byte, repeated first start byte
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(START_B);
      push_byte(START_A);
      push_byte(START_A);
      push_byte(START_A);
      push_frame(16'd0, 16'd0, 16'd0, LEN_WORD, 1'b0, 1, 31);
      push_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, LEN_WORD, 1'b0, 0, 31);
      push_frame(16'd7, 16'd501, 16'd9, LEN_WORD, 1'b0, 0, 31);
      push_frame(16'd3, 16'd500, 16'd4, LEN_WORD, 1'b0, 0, 31);
      push_frame(16'd20, 16'd40, 16'd60, LEN_WORD, 1'b1, 0, 31);
      // wrong length word whose low byte restarts the hunt
      push_byte(START_A);
      push_byte(START_B);
      push_byte(8'h00);
      push_byte(START_A);
      push_frame(16'd11, 16'd151, 16'd33, LEN_WORD, 1'b0, 1, 31);
      push_frame(16'd1, 16'd2, 16'd3, 16'h011C, 1'b0, 0, 31);
      push_frame(16'd5, 16'd12, 16'd8, LEN_WORD, 1'b0, 0, 31);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      next_pause = PAUSE_EVERY;
      while (stim_count < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            push_frame(16'($urandom), pick_pm25(), 16'($urandom), LEN_WORD, 1'b0, 0, 31);
         end else if (pick < 78) begin
            push_frame(16'($urandom), pick_pm25(), 16'($urandom), LEN_WORD, 1'b1, 0, 31);
         end else if (pick < 84) begin
            len_word = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                   : {8'($urandom_range(0, 1)), START_A};
            if (len_word == LEN_WORD) len_word = LEN_WORD + 16'd1;
            push_frame(16'($urandom), pick_pm25(), 16'($urandom), len_word, 1'b0, 0, 31);
         end else if (pick < 90) begin
            push_frame(16'($urandom), pick_pm25(), 16'($urandom), LEN_WORD, 1'b0, 0,
                       $urandom_range(1, 30));
         end else begin
            n = $urandom_range(1, 8);
            repeat (n) push_byte(($urandom_range(0, 3) == 0) ? START_A
                                                             : 8'($urandom_range(0, 255)));
         end
         if (stim_count >= next_pause) begin
            wait_drained();
            next_pause += PAUSE_EVERY;
         end
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   always @(posedge clock) begin : driver
      logic       nv;
      logic [7:0] nb;
      int         gap_left;
      int         burst_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         nv = req_valid;
         nb = req_rx_byte;
         if (req_valid && !req_stall) begin
            track_byte(req_rx_byte);
            nv = 1'b0;
         end
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (rx_bytes_q.size() > 0) begin
               nv = 1'b1;
               nb = rx_bytes_q.pop_front();
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 40);
               end
               burst_left--;
               if (burst_left == 0) begin
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_valid <= nv;
         req_rx_byte <= nb;
      end
   end

   always @(posedge clock) begin : monitor
      frame_report_type want;
      logic             ns;
      int               mode_cycles;
      int               stall_mode;
      int               stall_run;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_reports_q.size() == 0) begin
            $error("unexpected result transaction: status %0d", rsp_frame_status);
            mismatches++;
         end else begin
            want = frame_reports_q.pop_front();
            check_field("frame_status", want.status, rsp_frame_status);
            check_field("pm1_value", want.pm1, rsp_pm1_value);
            check_field("pm25_value", want.pm25, rsp_pm25_value);
            check_field("pm10_value", want.pm10, rsp_pm10_value);
            check_field("aqi_index", want.aqi, rsp_aqi_index);
            check_field("aqi_category", want.category, rsp_aqi_category);
         end
      end
      if (mode_cycles == 0) begin
         mode_cycles = $urandom_range(200, 800);
         stall_mode = $urandom_range(0, 2);
         stall_run = 0;
      end
      mode_cycles--;
      case (stall_mode)
         0: ns = 1'b0;
         1: ns = ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               ns = 1'b1;
            end else begin
               ns = 1'b0;
               if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(5, 50);
            end
         end
      endcase
      rsp_stall <= ns;
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
